[rtl/fk_pkg.sv]
// shared types, constants and fixed-point helpers for the skeleton kinematics block
package fk_pkg;

    localparam int QW         = 16;  // quaternion component, q1.14
    localparam int PW         = 24;  // position component, q7.16
    localparam int TW         = 28;  // intermediate 2*(u x v), rounded
    localparam int UW         = 30;  // rounded u x t term
    localparam int AW         = 46;  // product accumulator
    localparam int SLOT_MAX_W = 8;   // slot field width for up to 256 joints
    localparam int QDEPTH     = 2;   // front to back queue depth
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic signed [QW-1:0] quat_c_t;
    typedef logic signed [PW-1:0] pos_c_t;

    typedef struct packed {
        logic                  is_root;
        logic                  parent_zero;
        logic [4:0]            parent_slot;
        logic [SLOT_MAX_W-1:0] slot;
        quat_c_t [3:0]         lq;
        pos_c_t [2:0]          off;
        logic                  last;
    } fk_job_t;

    typedef struct packed {
        quat_c_t [3:0] q;
        pos_c_t [2:0]  p;
    } fk_entry_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } fk_qstat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_QUAT,
        ST_QRND,
        ST_UV,
        ST_TRND,
        ST_UT,
        ST_UTRND,
        ST_WT,
        ST_FIN,
        ST_OUT
    } fk_state_t;

    typedef enum logic [1:0] {
        REG_ROOT_X = 2'd0,
        REG_ROOT_Y = 2'd1,
        REG_ROOT_Z = 2'd2
    } fk_reg_t;

    // hamilton product: bit k set means term k of that lane is subtracted
    localparam logic [3:0] QNEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    // cross product operand order: c[i] = a[CR_A[i]]*b[CR_B[i]] - a[CR_B[i]]*b[CR_A[i]]
    localparam logic [1:0] CR_A [3] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] CR_B [3] = '{2'd2, 2'd0, 2'd1};

    localparam logic signed [AW-1:0] Q_HI = AW'(32767);
    localparam logic signed [AW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [AW-1:0] P_HI = AW'(8388607);
    localparam logic signed [AW-1:0] P_LO = ~P_HI;

    // round half up then arithmetic shift
    function automatic logic signed [AW-1:0] rnd_sh(input logic signed [AW-1:0] x,
                                                    input int unsigned sh);
        logic signed [AW-1:0] half;
        half = '0;
        half[sh-1] = 1'b1;
        return (x + half) >>> sh;
    endfunction

    function automatic quat_c_t sat_q(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        y = (x > Q_HI) ? Q_HI : ((x < Q_LO) ? Q_LO : x);
        return y[QW-1:0];
    endfunction

    function automatic pos_c_t sat_p(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        y = (x > P_HI) ? P_HI : ((x < P_LO) ? P_LO : x);
        return y[PW-1:0];
    endfunction

endpackage

[rtl/fk_queue.sv]
// two-entry job queue between the front and the back
module fk_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fk_pkg::fk_job_t push_job,
    input  logic            pop,
    output logic            head_valid,
    output fk_pkg::fk_job_t head_job,
    output fk_pkg::fk_qstat_t stat
);
    import fk_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    fk_job_t            entry_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.count = count_reg;

endmodule

[rtl/fk_front.sv]
// input side: takes joint beats, assigns table slots, classifies and queues them
module fk_front #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  has_parent,
    input  logic [4:0]            parent_slot,
    input  fk_pkg::quat_c_t [3:0] local_q,
    input  fk_pkg::pos_c_t [2:0]  offset,
    input  logic                  last_in,
    input  logic                  q_pop,
    output logic                  q_valid,
    output fk_pkg::fk_job_t       q_head,
    output fk_pkg::fk_qstat_t     q_stat
);
    import fk_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOINTS);

    logic [SLOT_W-1:0] joint_cnt_reg;
    logic [SLOT_W-1:0] joint_cnt_next;
    logic              accept;
    fk_job_t           job;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        job.is_root     = !has_parent;
        job.parent_zero = (32'(parent_slot) >= MAX_JOINTS);
        job.parent_slot = parent_slot;
        job.slot        = SLOT_MAX_W'(joint_cnt_reg);
        job.lq          = local_q;
        job.off         = offset;
        job.last        = last_in;
        // wrap at the table size, restart after the final joint
        if (last_in || (joint_cnt_reg == SLOT_W'(MAX_JOINTS - 1)))
        begin
            joint_cnt_next = '0;
        end
        else
        begin
            joint_cnt_next = joint_cnt_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_cnt_reg <= '0;
        end
        else if (accept)
        begin
            joint_cnt_reg <= joint_cnt_next;
        end
    end

    fk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head),
        .stat       (q_stat)
    );

endmodule

[rtl/fk_back.sv]
// compute side: shared multiplier lanes, joint table and result register
module fk_back #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fk_pkg::pos_c_t [2:0] root_pos,
    input  logic                 q_valid,
    input  fk_pkg::fk_job_t      q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fk_pkg::pos_c_t [2:0] world_p,
    output fk_pkg::quat_c_t [3:0] world_q,
    output logic                 last_out
);
    import fk_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOINTS);
    localparam int ENT_W  = $bits(fk_entry_t);

    fk_state_t             state_reg;
    fk_state_t             state_next;
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic                  load_out;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    fk_job_t               job_reg;
    logic [ENT_W-1:0]      tab_mem [MAX_JOINTS];
    fk_entry_t             par_reg;
    fk_entry_t             par;
    logic signed [AW-1:0]  acc_reg [4];
    quat_c_t [3:0]         wq_reg;
    pos_c_t [2:0]          wp_reg;
    logic signed [TW-1:0]  t_reg [3];
    logic signed [UW-1:0]  ut_reg [3];

    pos_c_t [2:0]          res_p_reg;
    quat_c_t [3:0]         res_q_reg;
    logic                  res_last_reg;

    logic signed [QW-1:0]  op_a [4];
    logic signed [TW-1:0]  op_b [4];
    logic                  op_neg [4];
    logic signed [AW-1:0]  prod [4];
    logic signed [AW-1:0]  sum_full [3];

    logic [SLOT_MAX_W-1:0] rd_ext;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     wr_addr;

    assign rd_ext  = SLOT_MAX_W'(job_reg.parent_slot);
    assign rd_addr = rd_ext[SLOT_W-1:0];
    assign wr_addr = job_reg.slot[SLOT_W-1:0];
    assign par     = job_reg.parent_zero ? '0 : par_reg;

    // state sequencing and handshake
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = q_head.is_root ? ST_OUT : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_QUAT;
                cnt_next   = 2'd0;
            end
            ST_QUAT:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_QRND;
                end
            end
            ST_QRND:
            begin
                state_next = ST_UV;
                cnt_next   = 2'd0;
            end
            ST_UV:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    state_next = ST_TRND;
                end
            end
            ST_TRND:
            begin
                state_next = ST_UT;
                cnt_next   = 2'd0;
            end
            ST_UT:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    state_next = ST_UTRND;
                end
            end
            ST_UTRND: state_next = ST_WT;
            ST_WT:    state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // multiplier lane operand select
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            op_a[i]   = '0;
            op_b[i]   = '0;
            op_neg[i] = 1'b0;
        end
        case (state_reg)
            ST_QUAT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    op_a[i]   = par.q[cnt_reg];
                    op_b[i]   = TW'(job_reg.lq[cnt_reg ^ 2'(i)]);
                    op_neg[i] = QNEG[i][cnt_reg];
                end
            end
            ST_UV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    op_a[i]   = cnt_reg[0] ? wq_reg[CR_B[i] + 2'd1] : wq_reg[CR_A[i] + 2'd1];
                    op_b[i]   = cnt_reg[0] ? TW'(job_reg.off[CR_A[i]])
                                           : TW'(job_reg.off[CR_B[i]]);
                    op_neg[i] = cnt_reg[0];
                end
            end
            ST_UT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    op_a[i]   = cnt_reg[0] ? wq_reg[CR_B[i] + 2'd1] : wq_reg[CR_A[i] + 2'd1];
                    op_b[i]   = cnt_reg[0] ? t_reg[CR_A[i]] : t_reg[CR_B[i]];
                    op_neg[i] = cnt_reg[0];
                end
            end
            ST_WT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    op_a[i] = wq_reg[0];
                    op_b[i] = t_reg[i];
                end
            end
            default:
            begin
                op_neg[0] = 1'b0;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            prod[i] = op_a[i] * op_b[i];
        end
    end

    // final position sum before saturation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [AW-1:0] pp_e;
            logic signed [AW-1:0] off_e;
            logic signed [AW-1:0] ut_e;
            pp_e        = par.p[i];
            off_e       = job_reg.off[i];
            ut_e        = ut_reg[i];
            sum_full[i] = pp_e + off_e + rnd_sh(acc_reg[i], 14) + ut_e;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
            wq_reg  <= q_head.lq;
            wp_reg  <= root_pos;
        end
        case (state_reg)
            ST_READ:
            begin
                par_reg <= tab_mem[rd_addr];
                for (int i = 0; i < 4; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
            ST_QUAT, ST_UV, ST_UT, ST_WT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    acc_reg[i] <= op_neg[i] ? (acc_reg[i] - prod[i]) : (acc_reg[i] + prod[i]);
                end
            end
            ST_QRND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    wq_reg[i]  <= sat_q(rnd_sh(acc_reg[i], 14));
                    acc_reg[i] <= '0;
                end
            end
            ST_TRND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [AW-1:0] tr;
                    tr         = rnd_sh(acc_reg[i], 13);
                    t_reg[i]   <= tr[TW-1:0];
                    acc_reg[i] <= '0;
                end
            end
            ST_UTRND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [AW-1:0] ur;
                    ur         = rnd_sh(acc_reg[i], 14);
                    ut_reg[i]  <= ur[UW-1:0];
                    acc_reg[i] <= '0;
                end
            end
            ST_FIN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    wp_reg[i] <= sat_p(sum_full[i]);
                end
            end
            default:
            begin
                par_reg <= par_reg;
            end
        endcase
        if (load_out)
        begin
            tab_mem[wr_addr] <= {wq_reg, wp_reg};
            res_p_reg        <= wp_reg;
            res_q_reg        <= wq_reg;
            res_last_reg     <= job_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign world_p   = res_p_reg;
    assign world_q   = res_q_reg;
    assign last_out  = res_last_reg;

endmodule

[rtl/skeleton_forward_kinematics.sv]
// top level of the fixed-point skeleton forward kinematics block
//
// joints stream in on the input channel (in_valid / in_stall), parent before
// child; each beat yields exactly one result beat on the output channel
// (out_valid / out_stall) with the joint's world position and rotation.
// the k-th joint since reset or since the last beat with last_in set is
// stored in table slot k mod MAX_JOINTS; a child names its parent by that slot.
// the front takes a beat and parks it in a two-entry queue;
// the back runs one joint at a time on four shared multiplier lanes.
// a root joint goes straight to the output register; a child joint goes through
// a table read, 4 product steps, rounding, two cross products and the final sum.
// the back takes its next joint from the queue only once the last one has
// left for the output register.
// when the receiver stalls the finished result holds in the output register,
// the back waits after its next joint and the queue fills, then in_stall rises.
// reset clears the joint counter, the queue and the root position registers;
// table contents are undefined until written.
// root position registers are written through cfg_we / cfg_index / cfg_data.
module skeleton_forward_kinematics #(
    parameter int MAX_JOINTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        has_parent,
    input  logic [4:0]  parent_slot,
    input  logic signed [15:0] local_w,
    input  logic signed [15:0] local_x,
    input  logic signed [15:0] local_y,
    input  logic signed [15:0] local_z,
    input  logic signed [23:0] offset_x,
    input  logic signed [23:0] offset_y,
    input  logic signed [23:0] offset_z,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [23:0] world_x,
    output logic signed [23:0] world_y,
    output logic signed [23:0] world_z,
    output logic signed [15:0] world_rw,
    output logic signed [15:0] world_rx,
    output logic signed [15:0] world_ry,
    output logic signed [15:0] world_rz,
    output logic        last_out
);
    import fk_pkg::*;

    pos_c_t [2:0]  root_pos_reg;
    quat_c_t [3:0] local_q;
    pos_c_t [2:0]  offset;
    pos_c_t [2:0]  world_p;
    quat_c_t [3:0] world_q;

    logic          q_pop;
    logic          q_valid;
    fk_job_t       q_head;
    fk_qstat_t     q_stat;

    // root position registers: the user writes only while idle, not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_pos_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (fk_reg_t'(cfg_index))
                REG_ROOT_X: root_pos_reg[0] <= cfg_data;
                REG_ROOT_Y: root_pos_reg[1] <= cfg_data;
                REG_ROOT_Z: root_pos_reg[2] <= cfg_data;
                default:    root_pos_reg    <= root_pos_reg;
            endcase
        end
    end

    // pack the beat fields, component 0 is w or x
    assign local_q = {local_z, local_y, local_x, local_w};
    assign offset  = {offset_z, offset_y, offset_x};

    fk_front #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .has_parent  (has_parent),
        .parent_slot (parent_slot),
        .local_q     (local_q),
        .offset      (offset),
        .last_in     (last_in),
        .q_pop       (q_pop),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_stat      (q_stat)
    );

    fk_back #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .root_pos  (root_pos_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .world_p   (world_p),
        .world_q   (world_q),
        .last_out  (last_out)
    );

    assign world_x  = world_p[0];
    assign world_y  = world_p[1];
    assign world_z  = world_p[2];
    assign world_rw = world_q[0];
    assign world_rx = world_q[1];
    assign world_ry = world_q[2];
    assign world_rz = world_q[3];

`ifndef SYNTHESIS
    // the queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("job queue count above depth");

    // the back only takes a job that is there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_stat.count != '0))
        else $error("job popped from empty queue");

    // a full queue with no pop stays full and keeps stalling the input
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !q_pop) |=> in_stall)
        else $error("input not stalled while queue full");
`endif

endmodule

[sim/tb_skeleton_forward_kinematics.sv]
// testbench for skeleton_forward_kinematics: directed and random joints checked by a predictor
module tb_skeleton_forward_kinematics;
    import fk_pkg::*;

    localparam int SLOTS      = 32;
    localparam int STALL_STOP = 4000;  // cycles without any beat before giving up
    localparam int DRAIN      = 40;    // settling margin after the last owed result

    typedef struct packed {
        logic          has_parent;
        logic [4:0]    parent;
        quat_c_t [3:0] q;    // w, x, y, z
        pos_c_t [2:0]  off;  // x, y, z
        logic          last;
    } joint_t;

    typedef struct packed {
        pos_c_t [2:0]  p;
        quat_c_t [3:0] r;
        logic          last;
    } pose_t;

    // predicts world poses and keeps the ones still owed by the block
    class fk_scoreboard;
        pos_c_t      pos_tab [SLOTS][3];
        quat_c_t     rot_tab [SLOTS][4];
        bit          written [SLOTS];
        int unsigned slot_ctr;
        pos_c_t      root [3];
        pose_t       owed [$];
        int          errors;

        function longint round_sh(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp(longint x, int w);
            longint hi;
            hi = (longint'(1) << (w - 1)) - 1;
            return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
        endfunction

        // an accepted joint: compute its world pose, store it in its slot
        function void note_joint(joint_t j);
            longint pq [4];
            longint lq [4];
            longint wq [4];
            longint v [3];
            longint uv [3];
            longint t [3];
            longint ut [3];
            longint wp [3];
            pose_t  res;
            for (int i = 0; i < 4; i++)
                lq[i] = j.q[3 - i];
            for (int i = 0; i < 3; i++)
                v[i] = j.off[2 - i];
            if (!j.has_parent)
            begin
                for (int i = 0; i < 4; i++)
                    wq[i] = lq[i];
                for (int i = 0; i < 3; i++)
                    wp[i] = root[i];
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    pq[i] = rot_tab[j.parent][i];
                wq[0] = pq[0]*lq[0] - pq[1]*lq[1] - pq[2]*lq[2] - pq[3]*lq[3];
                wq[1] = pq[0]*lq[1] + pq[1]*lq[0] + pq[2]*lq[3] - pq[3]*lq[2];
                wq[2] = pq[0]*lq[2] + pq[2]*lq[0] + pq[3]*lq[1] - pq[1]*lq[3];
                wq[3] = pq[0]*lq[3] + pq[3]*lq[0] + pq[1]*lq[2] - pq[2]*lq[1];
                for (int i = 0; i < 4; i++)
                    wq[i] = clamp(round_sh(wq[i], 14), 16);
                // offset rotated by the new world rotation
                uv[0] = wq[2]*v[2] - wq[3]*v[1];
                uv[1] = wq[3]*v[0] - wq[1]*v[2];
                uv[2] = wq[1]*v[1] - wq[2]*v[0];
                for (int i = 0; i < 3; i++)
                    t[i] = round_sh(uv[i], 13);
                ut[0] = wq[2]*t[2] - wq[3]*t[1];
                ut[1] = wq[3]*t[0] - wq[1]*t[2];
                ut[2] = wq[1]*t[1] - wq[2]*t[0];
                for (int i = 0; i < 3; i++)
                    wp[i] = clamp(longint'(pos_tab[j.parent][i]) + v[i]
                                  + round_sh(wq[0]*t[i], 14) + round_sh(ut[i], 14), 24);
            end
            for (int i = 0; i < 3; i++)
            begin
                pos_tab[slot_ctr][i] = pos_c_t'(wp[i]);
                res.p[2 - i] = pos_c_t'(wp[i]);
            end
            for (int i = 0; i < 4; i++)
            begin
                rot_tab[slot_ctr][i] = quat_c_t'(wq[i]);
                res.r[3 - i] = quat_c_t'(wq[i]);
            end
            res.last = j.last;
            written[slot_ctr] = 1'b1;
            slot_ctr = j.last ? 0 : (slot_ctr + 1) % SLOTS;
            owed = {owed, res};
        endfunction

        function void cmp_field(string name, longint e, longint a);
            if (e != a)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        // a result beat from the block
        function void check_result(pose_t a);
            pose_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: result beat with nothing owed", $time);
                errors++;
                return;
            end
            e = owed.pop_front();
            cmp_field("world_x", e.p[2], a.p[2]);
            cmp_field("world_y", e.p[1], a.p[1]);
            cmp_field("world_z", e.p[0], a.p[0]);
            cmp_field("world_rw", e.r[3], a.r[3]);
            cmp_field("world_rx", e.r[2], a.r[2]);
            cmp_field("world_ry", e.r[1], a.r[1]);
            cmp_field("world_rz", e.r[0], a.r[0]);
            cmp_field("last_out", e.last, a.last);
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [23:0]   cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          has_parent = 1'b0;
    logic [4:0]    parent_slot = '0;
    quat_c_t       local_w = '0, local_x = '0, local_y = '0, local_z = '0;
    pos_c_t        offset_x = '0, offset_y = '0, offset_z = '0;
    logic          last_in = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    pos_c_t        world_x, world_y, world_z;
    quat_c_t       world_rw, world_rx, world_ry, world_rz;
    logic          last_out;

    fk_scoreboard  sb = new();
    bit            quiet = 1'b0;     // no idling in the final stretch
    bit            hold_req = 1'b0;  // ask the receiver for one long hold-off
    int            idle_cycles = 0;

    skeleton_forward_kinematics uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .has_parent(has_parent), .parent_slot(parent_slot),
        .local_w(local_w), .local_x(local_x), .local_y(local_y), .local_z(local_z),
        .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
        .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .world_rw(world_rw), .world_rx(world_rx), .world_ry(world_ry),
        .world_rz(world_rz), .last_out(last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result beats are checked as they are taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({world_z, world_y, world_x, world_rw, world_rx, world_ry,
                             world_rz, last_out} == 0 ? pose_t'(0) :
                            pose_t'({world_x, world_y, world_z,
                                     world_rw, world_rx, world_ry, world_rz, last_out}));
    end

    // watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_STOP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one joint beat, return at the edge that takes it
    task automatic send_joint(joint_t j);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        has_parent  <= j.has_parent;
        parent_slot <= j.parent;
        local_w     <= j.q[3];
        local_x     <= j.q[2];
        local_y     <= j.q[1];
        local_z     <= j.q[0];
        offset_x    <= j.off[2];
        offset_y    <= j.off[1];
        offset_z    <= j.off[0];
        last_in     <= j.last;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_joint(j);
    endtask

    // drop valid, let every owed result come out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_root(fk_reg_t idx, pos_c_t v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.root[idx] = v;
    endtask

    task automatic write_roots(pos_c_t x, pos_c_t y, pos_c_t z);
        write_root(REG_ROOT_X, x);
        write_root(REG_ROOT_Y, y);
        write_root(REG_ROOT_Z, z);
        @(posedge clk);
    endtask

    function automatic quat_c_t rand_quat_c();
        case ($urandom_range(0, 3))
            0: return quat_c_t'($urandom);
            1: return quat_c_t'($urandom_range(0, 32768) - 16384);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return quat_c_t'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic pos_c_t rand_pos_c();
        case ($urandom_range(0, 3))
            0: return pos_c_t'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return pos_c_t'($urandom_range(0, 1 << 19) - (1 << 18));
        endcase
    endfunction

    function automatic joint_t mk_joint(bit hp, int par, int w, int x, int y, int z,
                                        int ox, int oy, int oz, bit last);
        joint_t j;
        j.has_parent = hp;
        j.parent     = par[4:0];
        j.q          = {quat_c_t'(w), quat_c_t'(x), quat_c_t'(y), quat_c_t'(z)};
        j.off        = {pos_c_t'(ox), pos_c_t'(oy), pos_c_t'(oz)};
        j.last       = last;
        return j;
    endfunction

    // random joint whose parent, if any, is a slot already written
    function automatic joint_t rand_joint(bit last);
        joint_t j;
        int     cur;
        bit     any;
        int     p;
        cur = sb.slot_ctr;
        any = 1'b0;
        foreach (sb.written[i])
            any |= sb.written[i];
        j.parent = 5'($urandom);
        j.has_parent = any && ($urandom_range(0, 9) != 0);
        if (j.has_parent)
        begin
            if (cur > 0 && $urandom_range(0, 7) != 0)
                p = $urandom_range(cur - 1, 0);
            else
            begin
                // any written slot, possibly at or after this one (stale entry)
                p = $urandom_range(0, SLOTS - 1);
                while (!sb.written[p])
                    p = $urandom_range(0, SLOTS - 1);
            end
            j.parent = p[4:0];
        end
        j.q   = {rand_quat_c(), rand_quat_c(), rand_quat_c(), rand_quat_c()};
        j.off = {rand_pos_c(), rand_pos_c(), rand_pos_c()};
        j.last = last;
        return j;
    endfunction

    // whole skeletons of random length; some run past the table and wrap
    task automatic run_poses(int n, int hold_at);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 20);
            for (int k = 0; k < len; k++)
            begin
                if (sent == hold_at)
                    hold_req = 1'b1;
                send_joint(rand_joint(k == len - 1));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_roots(24'sh7fffff, 24'sh800000, 24'sh000001);

        // directed: extremes, saturation, stale parent, end of skeleton
        send_joint(mk_joint(0, 31, 16384, 0, 0, 0, 8388607, 8388607, 8388607, 0));
        send_joint(mk_joint(1, 0, 32767, 32767, 32767, 32767, 8388607, 8388607, 8388607, 0));
        send_joint(mk_joint(1, 1, -32768, -32768, -32768, -32768,
                            -8388608, -8388608, -8388608, 0));
        send_joint(mk_joint(1, 0, 0, -32768, 0, 32767, 8388607, -8388608, 0, 0));
        send_joint(mk_joint(1, 3, 11585, 11585, 0, 0, 0, 0, 0, 0));
        send_joint(mk_joint(0, 0, -32768, 32767, -32768, 32767, 0, 0, 0, 0));
        send_joint(mk_joint(1, 5, 16384, 0, 0, 0, -8388608, 65536, -65536, 1));
        // slot 0 again: parents at or after the current slot read last pose's entries
        send_joint(mk_joint(1, 5, 16384, 16384, 0, 0, 65536, 0, 0, 0));
        send_joint(mk_joint(1, 6, 0, 0, 32767, 0, 0, 131072, 0, 0));
        send_joint(mk_joint(1, 1, 23170, 0, 0, -23170, 4194304, -4194304, 1, 0));
        send_joint(mk_joint(1, 2, -16384, 0, 0, 0, 100, -100, 8388607, 0));
        send_joint(mk_joint(1, 4, 0, 0, 0, 0, -1, -1, -1, 0));
        send_joint(mk_joint(0, 17, 0, 0, 0, 0, -1, 1, -1, 1));
        wait_idle();

        write_roots(24'sh800000, 24'sh7fffff, 24'sh800000);
        run_poses(150, 60);
        wait_idle();

        write_roots(pos_c_t'($urandom), pos_c_t'($urandom), pos_c_t'($urandom));
        run_poses(150, -1);
        wait_idle();

        // final stretch without any idling
        quiet = 1'b1;
        write_roots('0, pos_c_t'($urandom), '0);
        run_poses(190, -1);
        wait_idle();

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
rtl/fk_pkg.sv
rtl/fk_queue.sv
rtl/fk_front.sv
rtl/fk_back.sv
rtl/skeleton_forward_kinematics.sv
sim/tb_skeleton_forward_kinematics.sv
